>>> src/a2dpt_pkg.sv
// ============================================================================
// a2dpt_pkg
// Types, constants and the control store shared by the 2D affine transform.
// ============================================================================
package a2dpt_pkg;

    // Field and datapath widths
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int MAT_N     = 6;
    localparam int MAT_IDX_W = 3;
    localparam int PC_W      = 6;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_POINT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROTATE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IDENTITY  = 3'd4;

    // Matrix entry slots, row-vector form
    localparam logic [MAT_IDX_W-1:0] M00 = 3'd0;
    localparam logic [MAT_IDX_W-1:0] M01 = 3'd1;
    localparam logic [MAT_IDX_W-1:0] M10 = 3'd2;
    localparam logic [MAT_IDX_W-1:0] M11 = 3'd3;
    localparam logic [MAT_IDX_W-1:0] M20 = 3'd4;
    localparam logic [MAT_IDX_W-1:0] M21 = 3'd5;

    // Angle handling
    localparam int DEG_QUARTER    = 90;
    localparam int DEG_HALF_TURN  = 180;
    localparam int DEG_3QUARTER   = 270;
    localparam int DEG_FULL_TURN  = 360;
    localparam int SINE_N         = DEG_QUARTER + 1;
    // 2^31 mod 360 is 128, so the sign-bias offset contributes 360 - 128
    localparam int DEG_BIAS       = 232;
    localparam int DIV45          = 45;
    // floor(2^35 / 45): quotient estimate low by at most one
    localparam logic [29:0] RECIP45 = 30'd763549741;
    localparam int RECIP_SHIFT    = 35;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [SINE_N-1:0][DATA_W-1:0] sine_rom_t;

    // Request and result payloads
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] arg_x;
        logic signed [DATA_W-1:0] arg_y;
    } point_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic                     saturated;
    } point_res_t;

    // Sequencer state
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // Control word fields
    typedef enum logic [2:0] {
        OPA_ZERO,
        OPA_MAT,
        OPA_ARGX,
        OPA_ARGY,
        OPA_ONE
    } opa_t;

    typedef enum logic [2:0] {
        OPB_ONE,
        OPB_ARGX,
        OPB_ARGY,
        OPB_COS,
        OPB_SIN
    } opb_t;

    typedef enum logic {
        DST_MAT,
        DST_RES_X
    } dst_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_END,
        SEQ_EMIT
    } seq_t;

    typedef struct packed {
        logic                 mul_en;
        opa_t                 opa_sel;
        logic [MAT_IDX_W-1:0] rd_idx;
        opb_t                 opb_sel;
        logic                 acc_clr;
        logic                 acc_neg;
        logic                 wr_en;
        dst_t                 wr_dst;
        logic [MAT_IDX_W-1:0] wr_idx;
        seq_t                 seq;
    } ucode_t;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    // Program entry points
    localparam logic [PC_W-1:0] PC_POINT     = 6'd0;
    localparam logic [PC_W-1:0] PC_TRANSLATE = 6'd8;
    localparam logic [PC_W-1:0] PC_ROTATE    = 6'd14;
    localparam logic [PC_W-1:0] PC_SCALE     = 6'd32;
    localparam logic [PC_W-1:0] PC_IDENTITY  = 6'd40;
    localparam logic [PC_W-1:0] PC_NONE      = 6'd49;

    // Sine of k degrees in Q2.30, odd series to the x^15 term
    function automatic longint unsigned quarter_sine_q30(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = longint'(k) * PI_Q30 / DEG_HALF_TURN;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        return longint'(sum);
    endfunction

    // Quarter-wave table rounded half up to the chosen fraction width
    function automatic sine_rom_t build_sine_rom(input int frac);
        sine_rom_t       rom;
        longint unsigned v;
        for (int k = 0; k < SINE_N; k++) begin
            v = quarter_sine_q30(k);
            v = (v + (64'd1 << (29 - frac))) >> (30 - frac);
            rom[k] = DATA_W'(v);
        end
        return rom;
    endfunction

    // Clip a wide signed value to 32 bits
    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t                    s;
        logic [ACC_W-DATA_W:0]   hi;
        hi = v[ACC_W-1:DATA_W-1];
        s.clip = !((&hi) || !(|hi));
        if (!s.clip) begin
            s.val = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            s.val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            s.val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s;
    endfunction

    // Build one control word
    function automatic ucode_t mk(input logic mul, input opa_t a,
                                  input logic [MAT_IDX_W-1:0] ai, input opb_t b,
                                  input logic clr, input logic neg, input logic wr,
                                  input dst_t d, input logic [MAT_IDX_W-1:0] wi,
                                  input seq_t s);
        ucode_t w;
        w.mul_en  = mul;
        w.opa_sel = a;
        w.rd_idx  = ai;
        w.opb_sel = b;
        w.acc_clr = clr;
        w.acc_neg = neg;
        w.wr_en   = wr;
        w.wr_dst  = d;
        w.wr_idx  = wi;
        w.seq     = s;
        return w;
    endfunction

    // Control store. A product is registered in prod_reg and then added into
    // the accumulator, so each write waits until its group's last product lands.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            // transform point
            6'd0:  w = mk(1, OPA_MAT, M00, OPB_ARGX, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd1:  w = mk(1, OPA_MAT, M10, OPB_ARGY, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd2:  w = mk(1, OPA_MAT, M20, OPB_ONE,  0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd3:  w = mk(1, OPA_MAT, M01, OPB_ARGX, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd4:  w = mk(1, OPA_MAT, M11, OPB_ARGY, 0, 0, 1, DST_RES_X, M00, SEQ_NEXT);
            6'd5:  w = mk(1, OPA_MAT, M21, OPB_ONE,  0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd6:  w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd7:  w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_EMIT);
            // translate
            6'd8:  w = mk(1, OPA_MAT, M20, OPB_ONE,  1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd9:  w = mk(1, OPA_ARGX, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd10: w = mk(1, OPA_MAT, M21, OPB_ONE,  1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd11: w = mk(1, OPA_ARGY, M00, OPB_ONE, 0, 0, 1, DST_MAT, M20, SEQ_NEXT);
            6'd12: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd13: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M21, SEQ_END);
            // rotate: wait for sine and cosine, then rotate one row at a time
            6'd14: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd15: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd16: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd17: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd18: w = mk(1, OPA_MAT, M00, OPB_COS, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd19: w = mk(1, OPA_MAT, M01, OPB_SIN, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd20: w = mk(1, OPA_MAT, M01, OPB_COS, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd21: w = mk(1, OPA_MAT, M00, OPB_SIN, 0, 1, 1, DST_MAT, M00, SEQ_NEXT);
            6'd22: w = mk(1, OPA_MAT, M10, OPB_COS, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd23: w = mk(1, OPA_MAT, M11, OPB_SIN, 0, 0, 1, DST_MAT, M01, SEQ_NEXT);
            6'd24: w = mk(1, OPA_MAT, M11, OPB_COS, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd25: w = mk(1, OPA_MAT, M10, OPB_SIN, 0, 1, 1, DST_MAT, M10, SEQ_NEXT);
            6'd26: w = mk(1, OPA_MAT, M20, OPB_COS, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd27: w = mk(1, OPA_MAT, M21, OPB_SIN, 0, 0, 1, DST_MAT, M11, SEQ_NEXT);
            6'd28: w = mk(1, OPA_MAT, M21, OPB_COS, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd29: w = mk(1, OPA_MAT, M20, OPB_SIN, 0, 1, 1, DST_MAT, M20, SEQ_NEXT);
            6'd30: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd31: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M21, SEQ_END);
            // scale
            6'd32: w = mk(1, OPA_MAT, M00, OPB_ARGX, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd33: w = mk(1, OPA_MAT, M01, OPB_ARGY, 1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd34: w = mk(1, OPA_MAT, M10, OPB_ARGX, 1, 0, 1, DST_MAT, M00, SEQ_NEXT);
            6'd35: w = mk(1, OPA_MAT, M11, OPB_ARGY, 1, 0, 1, DST_MAT, M01, SEQ_NEXT);
            6'd36: w = mk(1, OPA_MAT, M20, OPB_ARGX, 1, 0, 1, DST_MAT, M10, SEQ_NEXT);
            6'd37: w = mk(1, OPA_MAT, M21, OPB_ARGY, 1, 0, 1, DST_MAT, M11, SEQ_NEXT);
            6'd38: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M20, SEQ_NEXT);
            6'd39: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M21, SEQ_END);
            // load identity
            6'd40: w = mk(1, OPA_ONE, M00, OPB_ONE,  1, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd41: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd42: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M00, SEQ_NEXT);
            6'd43: w = mk(1, OPA_ZERO, M00, OPB_ONE, 1, 0, 1, DST_MAT, M11, SEQ_NEXT);
            6'd44: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_NEXT);
            6'd45: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M01, SEQ_NEXT);
            6'd46: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M10, SEQ_NEXT);
            6'd47: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M20, SEQ_NEXT);
            6'd48: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 1, DST_MAT, M21, SEQ_END);
            // unused modes and spare addresses: finish at once
            default: w = mk(0, OPA_ZERO, M00, OPB_ONE, 0, 0, 0, DST_MAT, M00, SEQ_END);
        endcase
        return w;
    endfunction

    // Program start for each mode
    function automatic logic [PC_W-1:0] entry_pc(input logic [MODE_W-1:0] mode);
        logic [PC_W-1:0] pc;
        unique case (mode)
            MODE_POINT:     pc = PC_POINT;
            MODE_TRANSLATE: pc = PC_TRANSLATE;
            MODE_ROTATE:    pc = PC_ROTATE;
            MODE_SCALE:     pc = PC_SCALE;
            MODE_IDENTITY:  pc = PC_IDENTITY;
            default:        pc = PC_NONE;
        endcase
        return pc;
    endfunction

endpackage

>>> src/affine_2d_point_transform.sv
// ============================================================================
// affine_2d_point_transform
// 2D homogeneous affine transform in row-vector form, microcoded datapath.
// ============================================================================
// Usage:
//   Requests enter on req_valid/req_stall/req_data; each request carries a
//   mode and two Q16.16 arguments (for rotate, arg_x is an angle in whole
//   degrees). Mode 0 transforms a point and returns one result on
//   res_valid/res_stall/res_data; modes 1..4 update the matrix and return
//   nothing; modes 5..7 are dropped.
//   One request is worked at a time; req_stall is high while a program runs.
//   A request occupies the block for an accept cycle plus its program,
//   whose length is set by the single 32x32 multiplier, which takes one
//   product per step, and for rotate by the four-stage angle unit (modulo
//   360 and sine lookup) that must settle before the first product.
//   The transform result appears in the output register in the cycle after
//   its last step. If the receiver stalls, the result is held and the next
//   request is still accepted; a following transform then waits at its
//   final step until the output register is free.
//   Reset loads the identity matrix and leaves the block idle.
// ============================================================================
module affine_2d_point_transform
    import a2dpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  point_req_t req_data,
    output logic       res_valid,
    input  logic       res_stall,
    output point_res_t res_data
);

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) <<< FRAC_BITS;
    localparam sine_rom_t SINE_ROM = build_sine_rom(FRAC_BITS);

    // Sine of 0..359 degrees by quadrant symmetry
    function automatic logic signed [DATA_W-1:0] sine_deg(input logic [8:0] r);
        logic signed [DATA_W-1:0] v;
        priority if (r <= 9'(DEG_QUARTER)) begin
            v = $signed(SINE_ROM[r[6:0]]);
        end else if (r <= 9'(DEG_HALF_TURN)) begin
            v = $signed(SINE_ROM[7'(9'(DEG_HALF_TURN) - r)]);
        end else if (r <= 9'(DEG_3QUARTER)) begin
            v = -$signed(SINE_ROM[7'(r - 9'(DEG_HALF_TURN))]);
        end else begin
            v = -$signed(SINE_ROM[7'(9'(DEG_FULL_TURN) - r)]);
        end
        return v;
    endfunction

    // Sequencer
    seq_state_t          state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    ucode_t              uw;
    logic                accept;
    logic                emit_block;
    logic                do_mul, do_wr, do_emit;

    // Datapath
    logic signed [DATA_W-1:0] arg_x_reg, arg_y_reg;
    logic signed [DATA_W-1:0] mat_reg [MAT_N];
    logic signed [DATA_W-1:0] mat_rd, opa_val, opb_val;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pend_mul_reg, pend_clr_reg, pend_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg, addend, acc_shr;
    sat_t                     sat_now;
    logic signed [DATA_W-1:0] res_x_reg;
    logic                     res_clip_reg;
    logic                     res_valid_reg;
    point_res_t               res_data_reg;

    // Angle unit
    logic [DATA_W-1:0]   ang_u;
    logic [28:0]         ang_v_reg;
    logic [2:0]          ang_lo1_reg, ang_lo2_reg;
    logic [58:0]         ang_prod_reg;
    logic [23:0]         ang_q;
    logic [28:0]         ang_q45, ang_rem_full;
    logic [6:0]          ang_rem7;
    logic [5:0]          ang_rem_reg;
    logic [9:0]          ang_d1;
    logic [8:0]          ang_deg_reg, ang_deg_next, cos_idx;
    logic signed [DATA_W-1:0] sin_reg, cos_reg;

    assign uw        = ucode_rom(pc_reg);
    assign accept    = req_valid && !req_stall;
    assign emit_block = res_valid_reg && res_stall;

    // Next state and step counter
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RUN;
                    pc_next    = entry_pc(req_data.mode);
                end
            end
            ST_RUN:
            begin
                unique case (uw.seq)
                    SEQ_NEXT: pc_next = pc_reg + PC_W'(1);
                    SEQ_END:  state_next = ST_IDLE;
                    SEQ_EMIT:
                    begin
                        if (!emit_block)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:  state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Step outputs
    always_comb
    begin
        req_stall = 1'b1;
        do_mul    = 1'b0;
        do_wr     = 1'b0;
        do_emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_stall = 1'b0;
            ST_RUN:
            begin
                do_mul  = uw.mul_en;
                do_wr   = uw.wr_en;
                do_emit = (uw.seq == SEQ_EMIT) && !emit_block;
            end
            default: req_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= PC_NONE;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // Capture request arguments
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arg_x_reg <= req_data.arg_x;
            arg_y_reg <= req_data.arg_y;
        end
    end

    // Angle unit: reduce modulo 360 via 8 * 45 and a reciprocal, then look up
    assign ang_u        = {~arg_x_reg[DATA_W-1], arg_x_reg[DATA_W-2:0]};
    assign ang_q        = ang_prod_reg[58:RECIP_SHIFT];
    assign ang_q45      = (29'(ang_q) << 5) + (29'(ang_q) << 3) + (29'(ang_q) << 2)
                          + 29'(ang_q);
    assign ang_rem_full = ang_v_reg - ang_q45;
    assign ang_rem7     = ang_rem_full[6:0];
    assign ang_d1       = 10'({ang_rem_reg, ang_lo2_reg}) + 10'(DEG_BIAS);
    assign ang_deg_next = (ang_d1 >= 10'(DEG_FULL_TURN)) ?
                          9'(ang_d1 - 10'(DEG_FULL_TURN)) : ang_d1[8:0];
    assign cos_idx      = (ang_deg_reg >= 9'(DEG_3QUARTER)) ?
                          (ang_deg_reg - 9'(DEG_3QUARTER)) :
                          (ang_deg_reg + 9'(DEG_QUARTER));

    always_ff @(posedge clk)
    begin
        ang_v_reg    <= ang_u[DATA_W-1:3];
        ang_lo1_reg  <= ang_u[2:0];
        ang_prod_reg <= {30'd0, ang_u[DATA_W-1:3]} * {29'd0, RECIP45};
        ang_rem_reg  <= (ang_rem7 >= 7'(DIV45)) ? 6'(ang_rem7 - 7'(DIV45)) : ang_rem7[5:0];
        ang_lo2_reg  <= ang_lo1_reg;
        ang_deg_reg  <= ang_deg_next;
        sin_reg      <= sine_deg(ang_deg_reg);
        cos_reg      <= sine_deg(cos_idx);
    end

    // Operand selection
    assign mat_rd = (uw.rd_idx < MAT_IDX_W'(MAT_N)) ? mat_reg[uw.rd_idx] : '0;

    always_comb
    begin
        unique case (uw.opa_sel)
            OPA_MAT:  opa_val = mat_rd;
            OPA_ARGX: opa_val = arg_x_reg;
            OPA_ARGY: opa_val = arg_y_reg;
            OPA_ONE:  opa_val = ONE_Q;
            default:  opa_val = '0;
        endcase
    end

    always_comb
    begin
        unique case (uw.opb_sel)
            OPB_ARGX: opb_val = arg_x_reg;
            OPB_ARGY: opb_val = arg_y_reg;
            OPB_COS:  opb_val = cos_reg;
            OPB_SIN:  opb_val = sin_reg;
            default:  opb_val = ONE_Q;
        endcase
    end

    // Multiply into prod_reg, then accumulate from it
    always_ff @(posedge clk)
    begin
        if (do_mul)
        begin
            prod_reg     <= opa_val * opb_val;
            pend_clr_reg <= uw.acc_clr;
            pend_neg_reg <= uw.acc_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mul_reg <= 1'b0;
        end
        else
        begin
            pend_mul_reg <= do_mul;
        end
    end

    assign addend = pend_neg_reg ?
                    -$signed({{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg}) :
                    $signed({{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});

    always_ff @(posedge clk)
    begin
        if (pend_mul_reg)
        begin
            acc_reg <= pend_clr_reg ? addend : (acc_reg + addend);
        end
    end

    // Floor to the fraction point and clip
    assign acc_shr = acc_reg >>> FRAC_BITS;
    assign sat_now = sat32(acc_shr);

    // Matrix write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_N; i++)
            begin
                mat_reg[i] <= (i == int'(M00) || i == int'(M11)) ? ONE_Q : '0;
            end
        end
        else if (do_wr && uw.wr_dst == DST_MAT)
        begin
            for (int i = 0; i < MAT_N; i++)
            begin
                if (uw.wr_idx == MAT_IDX_W'(i))
                begin
                    mat_reg[i] <= sat_now.val;
                end
            end
        end
    end

    // Hold the x coordinate of a point until y is ready
    always_ff @(posedge clk)
    begin
        if (do_wr && uw.wr_dst == DST_RES_X)
        begin
            res_x_reg    <= sat_now.val;
            res_clip_reg <= sat_now.clip;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (do_emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            res_data_reg.out_x     <= res_x_reg;
            res_data_reg.out_y     <= sat_now.val;
            res_data_reg.saturated <= res_clip_reg | sat_now.clip;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
